// ===== rtl/dltq_pkg.sv =====
package dltq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TICK_BITS   = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int FIRE_W  = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W = TICK_BITS + 8;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [FIRE_W-1:0]    fire_t;
    typedef logic [TICK_BITS-1:0] tick_t;

    typedef struct packed {
        tick_t      delta;
        logic [7:0] id;
    } entry_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;

    localparam logic [32:0] TICK_MAX = (33'd1 << TICK_BITS) - 33'd1;

    // clamp a 16-bit request delay to what the store can hold
    function automatic tick_t sat_delay(logic [15:0] d);
        logic [32:0] w;
        w = 33'(d);
        if (w > TICK_MAX) begin
            w = TICK_MAX;
        end
        return tick_t'(w);
    endfunction

    // ring position of the entry at logical offset off from the head
    function automatic idx_t phys_addr(idx_t head, cnt_t off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            s = s - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return idx_t'(s);
    endfunction

endpackage

// ===== rtl/dltq_ram.sv =====
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/delta_list_timer_queue.sv =====
// Delta-list timer queue. Entries live in a ring buffer in one RAM, each holding an event id
// and its delay relative to the entry ahead of it. One item is worked at a time; s_tready is
// high only while the queue controller is idle. An insert walks the RAM one entry a cycle to
// find the slot, then moves the later entries up one a cycle. A full queue answers with a
// reject. A tick fires at most 16 events; each fired result waits until the entry behind it
// has been read back from the RAM, which shows whether that result is the last. Stalls on
// the result channel hold the controller while a result waits; one finished result may wait
// in the output register while the next item is taken.
module delta_list_timer_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // delay_ticks[15:0], event_id[23:16]
    input  logic        s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // fired_event[7:0], pending_count[12:8], zero[15:13]
    output logic [1:0]  m_tuser,  // result_kind
    output logic        m_tlast   // last
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEARCH = 8'b0000_0010,
        ST_SHIFT  = 8'b0000_0100,
        ST_PLACE  = 8'b0000_1000,
        ST_REPLY  = 8'b0001_0000,
        ST_TICK   = 8'b0010_0000,
        ST_FIRE   = 8'b0100_0000,
        ST_LAST   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    dltq_pkg::idx_t    head_reg, head_next;
    dltq_pkg::cnt_t    count_reg, count_next;
    dltq_pkg::cnt_t    pos_reg, pos_next;
    dltq_pkg::cnt_t    sh_reg, sh_next;
    dltq_pkg::tick_t   rem_reg, rem_next;
    logic [7:0]        id_reg, id_next;
    logic [7:0]        pend_id_reg, pend_id_next;
    dltq_pkg::cnt_t    pend_cnt_reg, pend_cnt_next;
    dltq_pkg::fire_t   fired_reg, fired_next;

    logic              m_valid_reg;
    logic [1:0]        m_kind_reg;
    logic [7:0]        m_id_reg;
    logic [4:0]        m_cnt_reg;
    logic              m_last_reg;

    logic              emit;
    logic [1:0]        emit_kind;
    logic [7:0]        emit_id;
    dltq_pkg::cnt_t    emit_cnt;
    logic              emit_last;

    logic              rd_en, wr_en;
    dltq_pkg::idx_t    rd_addr, wr_addr;
    dltq_pkg::entry_t  wr_entry, rd_entry;
    logic [dltq_pkg::ENTRY_W-1:0] rd_data;

    logic              slot_free;
    dltq_pkg::cnt_t    cnt_less;
    dltq_pkg::fire_t   fired_inc;

    dltq_ram #(
        .WIDTH(dltq_pkg::ENTRY_W),
        .DEPTH(dltq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk    (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_entry),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign rd_entry  = dltq_pkg::entry_t'(rd_data);
    assign slot_free = !m_valid_reg || m_tready;
    assign cnt_less  = count_reg - dltq_pkg::cnt_t'(1);
    assign fired_inc = fired_reg + dltq_pkg::fire_t'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_cnt_reg, m_id_reg};

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        sh_next       = sh_reg;
        rem_next      = rem_reg;
        id_next       = id_reg;
        pend_id_next  = pend_id_reg;
        pend_cnt_next = pend_cnt_reg;
        fired_next    = fired_reg;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        wr_entry      = '0;
        emit          = 1'b0;
        emit_kind     = dltq_pkg::KIND_ACCEPT;
        emit_id       = id_reg;
        emit_cnt      = count_reg;
        emit_last     = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == dltq_pkg::REQ_INSERT) begin
                        id_next  = s_tdata[23:16];
                        rem_next = dltq_pkg::sat_delay(s_tdata[15:0]);
                        pos_next = '0;
                        if (count_reg == dltq_pkg::cnt_t'(dltq_pkg::QUEUE_DEPTH)) begin
                            state_next = ST_REPLY;
                        end else if (count_reg == '0) begin
                            state_next = ST_PLACE;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = ST_SEARCH;
                        end
                    end else if (count_reg != '0) begin
                        rd_en      = 1'b1;
                        state_next = ST_TICK;
                    end
                end
            end
            ST_SEARCH: begin
                // rd_entry is the entry at pos_reg; advance past every entry due no later
                if (rd_entry.delta <= rem_reg) begin
                    rem_next = rem_reg - rd_entry.delta;
                    pos_next = pos_reg + dltq_pkg::cnt_t'(1);
                    if (pos_next < count_reg) begin
                        rd_en   = 1'b1;
                        rd_addr = dltq_pkg::phys_addr(head_reg, pos_next);
                    end else begin
                        state_next = ST_PLACE;
                    end
                end else begin
                    sh_next    = cnt_less;
                    rd_en      = 1'b1;
                    rd_addr    = dltq_pkg::phys_addr(head_reg, cnt_less);
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                // move entry sh_reg up one slot; the one displaced by the insert loses rem
                wr_en          = 1'b1;
                wr_addr        = dltq_pkg::phys_addr(head_reg, sh_reg + dltq_pkg::cnt_t'(1));
                wr_entry.id    = rd_entry.id;
                wr_entry.delta = (sh_reg == pos_reg) ? rd_entry.delta - rem_reg
                                                     : rd_entry.delta;
                if (sh_reg == pos_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    sh_next    = sh_reg - dltq_pkg::cnt_t'(1);
                    rd_en      = 1'b1;
                    rd_addr    = dltq_pkg::phys_addr(head_reg, sh_next);
                end
            end
            ST_PLACE: begin
                if (slot_free) begin
                    wr_en          = 1'b1;
                    wr_addr        = dltq_pkg::phys_addr(head_reg, pos_reg);
                    wr_entry.delta = rem_reg;
                    wr_entry.id    = id_reg;
                    count_next     = count_reg + dltq_pkg::cnt_t'(1);
                    emit           = 1'b1;
                    emit_cnt       = count_next;
                    state_next     = ST_IDLE;
                end
            end
            ST_REPLY: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_kind  = dltq_pkg::KIND_REJECT;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (rd_entry.delta > dltq_pkg::tick_t'(1)) begin
                    wr_en          = 1'b1;
                    wr_entry.delta = rd_entry.delta - dltq_pkg::tick_t'(1);
                    wr_entry.id    = rd_entry.id;
                    state_next     = ST_IDLE;
                end else begin
                    pend_id_next  = rd_entry.id;
                    head_next     = dltq_pkg::phys_addr(head_reg, dltq_pkg::cnt_t'(1));
                    count_next    = cnt_less;
                    pend_cnt_next = cnt_less;
                    fired_next    = dltq_pkg::fire_t'(1);
                    if (cnt_less == '0
                        || fired_next == dltq_pkg::fire_t'(dltq_pkg::MAX_RESULTS)) begin
                        state_next = ST_LAST;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = head_next;
                        state_next = ST_FIRE;
                    end
                end
            end
            ST_FIRE: begin
                // rd_entry is the new head; it decides whether the held result is the last
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_kind = dltq_pkg::KIND_FIRED;
                    emit_id   = pend_id_reg;
                    emit_cnt  = pend_cnt_reg;
                    emit_last = (rd_entry.delta != '0);
                    if (rd_entry.delta == '0) begin
                        pend_id_next  = rd_entry.id;
                        head_next     = dltq_pkg::phys_addr(head_reg, dltq_pkg::cnt_t'(1));
                        count_next    = cnt_less;
                        pend_cnt_next = cnt_less;
                        fired_next    = fired_inc;
                        if (cnt_less == '0
                            || fired_inc == dltq_pkg::fire_t'(dltq_pkg::MAX_RESULTS)) begin
                            state_next = ST_LAST;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = head_next;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LAST: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_kind  = dltq_pkg::KIND_FIRED;
                    emit_id    = pend_id_reg;
                    emit_cnt   = pend_cnt_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        id_reg       <= id_next;
        pend_id_reg  <= pend_id_next;
        pend_cnt_reg <= pend_cnt_next;
        fired_reg    <= fired_next;
        if (emit) begin
            m_kind_reg <= emit_kind;
            m_id_reg   <= emit_id;
            m_cnt_reg  <= 5'(emit_cnt);
            m_last_reg <= emit_last;
        end
    end

endmodule

// ===== rtl/dltq_checker.sv =====
module dltq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // reset empties the result channel
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // an insert always answers with a single, final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dltq_pkg::KIND_ACCEPT || m_tuser == dltq_pkg::KIND_REJECT)
        |-> m_tlast)
        else $error("insert result without last");

    // no new item while a fired run is still open
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dltq_pkg::KIND_FIRED && !m_tlast |-> !s_tready)
        else $error("item taken in the middle of a fired run");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

// ===== tb/sv/delta_list_timer_queue_tb.sv =====
module delta_list_timer_queue_tb;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ev;
        logic [4:0] cnt;
        logic       last;
    } timer_result_t;

    typedef struct packed {
        logic          req;
        logic [15:0]   dly;
        logic [7:0]    id;
        logic          typed;    // expected result written into the row
        logic          has_res;  // typed row gives one result
        timer_result_t exp;
    } dir_row_t;

    localparam int NUM_ROWS    = 23;
    localparam int NUM_RANDOM  = 500;
    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // delay_ticks[15:0], event_id[23:16]
    logic        s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // fired_event[7:0], pending_count[12:8], zero[15:13]
    logic [1:0]  m_tuser;   // result_kind
    logic        m_tlast;

    // timer queue as the block should hold it
    dltq_pkg::tick_t pend_delta[dltq_pkg::QUEUE_DEPTH];
    logic [7:0]      pend_id[dltq_pkg::QUEUE_DEPTH];
    int              pend_n;

    timer_result_t step_out[$];     // results of the item just taken
    timer_result_t due_results[$];  // results still to come from the block

    int  errors;
    int  items_sent;
    int  n_accept;
    int  n_reject;
    int  n_fired;
    bit  calm;
    bit  hold_req;

    delta_list_timer_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic timer_result_t mk_result(logic [1:0] kind, logic [7:0] ev,
                                                int cnt, logic last);
        timer_result_t r;
        r.kind = kind;
        r.ev   = ev;
        r.cnt  = 5'(cnt);
        r.last = last;
        return r;
    endfunction

    function automatic dir_row_t mk_row(logic req, logic [15:0] dly, logic [7:0] id,
                                        logic typed, logic has_res, timer_result_t exp);
        dir_row_t row;
        row.req     = req;
        row.dly     = dly;
        row.id      = id;
        row.typed   = typed;
        row.has_res = has_res;
        row.exp     = exp;
        return row;
    endfunction

    // advance the queue by one item and leave its results in step_out
    function automatic void predict_queue_step(logic req, logic [15:0] dly, logic [7:0] id);
        logic [32:0] rem;
        int          pos;
        int          i;
        int          fired;
        logic [7:0]  head_id;
        bit          more;
        step_out.delete();
        if (req == dltq_pkg::REQ_INSERT) begin
            if (pend_n >= dltq_pkg::QUEUE_DEPTH) begin
                step_out.push_back(mk_result(dltq_pkg::KIND_REJECT, id, pend_n, 1'b1));
                return;
            end
            rem = 33'(dly);
            if (rem > dltq_pkg::TICK_MAX) begin
                rem = dltq_pkg::TICK_MAX;
            end
            pos = 0;
            while (pos < pend_n && 33'(pend_delta[pos]) <= rem) begin
                rem = rem - 33'(pend_delta[pos]);
                pos++;
            end
            for (i = pend_n; i > pos; i--) begin
                pend_delta[i] = pend_delta[i-1];
                pend_id[i]    = pend_id[i-1];
            end
            pend_delta[pos] = dltq_pkg::tick_t'(rem);
            pend_id[pos]    = id;
            pend_n++;
            if (pos + 1 < pend_n) begin
                pend_delta[pos+1] = pend_delta[pos+1] - dltq_pkg::tick_t'(rem);
            end
            step_out.push_back(mk_result(dltq_pkg::KIND_ACCEPT, id, pend_n, 1'b1));
        end else begin
            if (pend_n == 0) begin
                return;
            end
            if (pend_delta[0] > 1) begin
                pend_delta[0] = pend_delta[0] - 1'b1;
                return;
            end
            pend_delta[0] = '0;
            fired = 0;
            while (pend_n > 0 && pend_delta[0] == 0 && fired < dltq_pkg::MAX_RESULTS) begin
                head_id = pend_id[0];
                for (i = 1; i < pend_n; i++) begin
                    pend_delta[i-1] = pend_delta[i];
                    pend_id[i-1]    = pend_id[i];
                end
                pend_n--;
                fired++;
                more = pend_n > 0 && pend_delta[0] == 0 && fired < dltq_pkg::MAX_RESULTS;
                step_out.push_back(mk_result(dltq_pkg::KIND_FIRED, head_id, pend_n, !more));
            end
        end
    endfunction

    // offer one item, wait for the handshake, then predict
    task automatic send_item(input logic req, input logic [15:0] dly, input logic [7:0] id);
        while (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {id, dly};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
        predict_queue_step(req, dly, id);
    endtask

    initial begin
        dir_row_t    rows[NUM_ROWS];
        int          k;
        int          r;
        int          burst;
        logic        req;
        logic [15:0] dly;
        logic [7:0]  id;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = dltq_pkg::REQ_INSERT;
        errors     = 0;
        items_sent = 0;
        n_accept   = 0;
        n_reject   = 0;
        n_fired    = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        pend_n     = 0;

        // tick on empty, both delay extremes, head due at zero, tick with nothing due,
        // a run of equal deadlines, full store, a tick firing a long run, then one more tick
        rows[0] = mk_row(dltq_pkg::REQ_TICK, 16'd0, 8'h00, 1'b1, 1'b0, '0);
        rows[1] = mk_row(dltq_pkg::REQ_INSERT, 16'd0, 8'h00, 1'b1, 1'b1,
                         mk_result(dltq_pkg::KIND_ACCEPT, 8'h00, 1, 1'b1));
        rows[2] = mk_row(dltq_pkg::REQ_INSERT, 16'hFFFF, 8'hFF, 1'b1, 1'b1,
                         mk_result(dltq_pkg::KIND_ACCEPT, 8'hFF, 2, 1'b1));
        rows[3] = mk_row(dltq_pkg::REQ_TICK, 16'hFFFF, 8'hFF, 1'b1, 1'b1,
                         mk_result(dltq_pkg::KIND_FIRED, 8'h00, 1, 1'b1));
        rows[4] = mk_row(dltq_pkg::REQ_TICK, 16'd0, 8'h00, 1'b1, 1'b0, '0);
        for (k = 0; k < 14; k++) begin
            rows[5+k] = mk_row(dltq_pkg::REQ_INSERT, 16'd1, 8'(k + 1), 1'b1, 1'b1,
                               mk_result(dltq_pkg::KIND_ACCEPT, 8'(k + 1), k + 2, 1'b1));
        end
        rows[19] = mk_row(dltq_pkg::REQ_INSERT, 16'd2, 8'hAA, 1'b1, 1'b1,
                          mk_result(dltq_pkg::KIND_ACCEPT, 8'hAA, 16, 1'b1));
        rows[20] = mk_row(dltq_pkg::REQ_INSERT, 16'd7, 8'h55, 1'b1, 1'b1,
                          mk_result(dltq_pkg::KIND_REJECT, 8'h55, 16, 1'b1));
        rows[21] = mk_row(dltq_pkg::REQ_TICK, 16'h5A5A, 8'h3C, 1'b0, 1'b0, '0);
        rows[22] = mk_row(dltq_pkg::REQ_TICK, 16'd0, 8'h00, 1'b1, 1'b1,
                          mk_result(dltq_pkg::KIND_FIRED, 8'hAA, 1, 1'b1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < NUM_ROWS; k++) begin
            send_item(rows[k].req, rows[k].dly, rows[k].id);
            if (rows[k].typed) begin
                if (rows[k].has_res) begin
                    due_results.push_back(rows[k].exp);
                end
            end else begin
                foreach (step_out[i]) due_results.push_back(step_out[i]);
            end
        end

        // mostly short delays so events keep firing; bursts of inserts fill the store
        burst = 0;
        for (k = 0; k < NUM_RANDOM; k++) begin
            calm = (k >= 300 && k < 400);
            if (k == 100) begin
                hold_req = 1'b1;
            end
            if (burst > 0) begin
                req = dltq_pkg::REQ_INSERT;
                burst--;
            end else if ($urandom_range(99) < 4) begin
                burst = $urandom_range(20, 8);
                req = dltq_pkg::REQ_INSERT;
            end else begin
                req = ($urandom_range(99) < 45) ? dltq_pkg::REQ_TICK : dltq_pkg::REQ_INSERT;
            end
            r = $urandom_range(99);
            if (r < 55) begin
                dly = 16'($urandom_range(3));
            end else if (r < 80) begin
                dly = 16'($urandom_range(40));
            end else if (r < 99) begin
                dly = 16'($urandom_range(1000));
            end else begin
                dly = 16'($urandom);
            end
            id = 8'($urandom);
            send_item(req, dly, id);
            foreach (step_out[i]) due_results.push_back(step_out[i]);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        $display("Ran %0d items: %0d inserts accepted, %0d rejected on a full store,",
                 items_sent, n_accept, n_reject);
        $display("%0d events fired, with a %0d-cycle output stall and a run with no idle cycles",
                 n_fired, HOLD_CYCLES);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // receiver: random back-pressure outside the calm phase, plus one long hold-off to fill the block
    initial begin
        int hold_left;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
                    @(posedge aclk);
                end
                hold_req = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 28);
            end
        end
    end

    always @(posedge aclk) begin
        timer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            case (m_tuser)
                dltq_pkg::KIND_ACCEPT: n_accept++;
                dltq_pkg::KIND_REJECT: n_reject++;
                dltq_pkg::KIND_FIRED:  n_fired++;
                default: ;
            endcase
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind=%0d id=%0h",
                                          m_tuser, m_tdata[7:0]));
            end else begin
                want = due_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("result_kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[7:0] !== want.ev)
                    report_mismatch($sformatf("fired_event %0h, want %0h", m_tdata[7:0], want.ev));
                if (m_tdata[12:8] !== want.cnt)
                    report_mismatch($sformatf("pending_count %0d, want %0d",
                                              m_tdata[12:8], want.cnt));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    initial begin
        #2000000;
        $display("Timeout: %0d results still outstanding", due_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
